[rtl/bcf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared constants, codes, types and saturating helpers of the biquad cascade.
// ----------------------------------------------------------------------------
package bcf_pkg;

  localparam int MAX_SECTIONS = 12;
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W        = 5;
  localparam int CA_W         = SEC_W + 2;
  localparam int COEF_DEPTH   = 1 << CA_W;
  localparam int DLY_W        = 128;
  localparam int SIG_FRAC     = 8;
  localparam int ADDR_W       = 4;

  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] SEL_A1   = 2'd0;
  localparam logic [1:0] SEL_A2   = 2'd1;
  localparam logic [1:0] SEL_GAIN = 2'd2;

  localparam logic [1:0] REG_HP     = 2'd0;
  localparam logic [1:0] REG_LP     = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (SIG_FRAC - 1);

  typedef struct packed {
    logic [2:0]         highpass_sections;
    logic [2:0]         lowpass_sections;
    logic signed [31:0] offset;
  } cfg_t;

  function automatic logic signed [63:0] sat65(input logic signed [64:0] s);
    logic signed [63:0] r;
    if (s[64] != s[63]) begin
      r = s[64] ? S64_MIN : S64_MAX;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    return sat65(s);
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    return sat65(s);
  endfunction

endpackage
`default_nettype wire

[rtl/bcf_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bcf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] sample;
  logic [3:0]         section;
  logic [1:0]         coef_sel;
  logic signed [31:0] coef_value;

  modport source (output valid, op, sample, section, coef_sel, coef_value, input ready);
  modport sink   (input valid, op, sample, section, coef_sel, coef_value, output ready);
endinterface

interface bcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_sample;
  logic               saturated;

  modport source (output valid, filtered_sample, saturated, input ready);
  modport sink   (input valid, filtered_sample, saturated, output ready);
endinterface
`default_nettype wire

[rtl/bcf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/bcf_qmul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_qmul
// 64x32 Q2.30 multiplier: registered half products, then round half-up and
// saturate to 64 bits.
// ----------------------------------------------------------------------------
module bcf_qmul import bcf_pkg::*; (
  input  logic               clk,
  input  logic signed [63:0] v,
  input  logic signed [31:0] c,
  output logic signed [63:0] prod
);

  localparam logic signed [96:0] RND_Q30 = 97'sd1 <<< 29;

  logic signed [32:0] v_lo;
  logic signed [31:0] v_hi;
  logic signed [64:0] pp_lo;
  logic signed [63:0] pp_hi;
  logic signed [64:0] pp_lo_r;
  logic signed [63:0] pp_hi_r;
  logic signed [96:0] acc;
  logic               fits;

  assign v_lo  = $signed({1'b0, v[31:0]});
  assign v_hi  = v[63:32];
  assign pp_lo = v_lo * c;
  assign pp_hi = v_hi * c;

  always_ff @(posedge clk) begin
    pp_lo_r <= pp_lo;
    pp_hi_r <= pp_hi;
  end

  assign acc  = $signed({pp_hi_r[63], pp_hi_r, 32'b0}) + 97'(pp_lo_r) + RND_Q30;
  assign fits = (&acc[96:93]) || ~(|acc[96:93]);
  assign prod = fits ? acc[93:30] : (acc[96] ? S64_MIN : S64_MAX);

endmodule
`default_nettype wire

[rtl/bcf_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_core
// Section sequencer: coefficient and delay RAMs, shared multiplier, delay
// write-back overlapped with the next section, output rounding and clip.
// ----------------------------------------------------------------------------
module bcf_core import bcf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_sample,
  input  logic [3:0]         in_section,
  input  logic [1:0]         in_coef_sel,
  input  logic signed [31:0] in_coef_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_filtered_sample,
  output logic               out_saturated
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE1 = 3'd1;
  localparam logic [2:0] S_PRE2 = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DR0  = 3'd4;
  localparam logic [2:0] S_DR1  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [1:0] PH_GAIN = 2'd0;
  localparam logic [1:0] PH_A1   = 2'd1;
  localparam logic [1:0] PH_A2   = 2'd2;

  localparam int CLIP_HI = SIG_FRAC + 31;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       ph_r;
  logic [SEC_W-1:0] k_r;
  logic             tv_r;
  logic [MAX_SECTIONS-1:0] dly_vld_r;
  logic             rd_vld_r;
  logic             out_valid_r;

  logic signed [63:0] x_r, xn_r, v_r, d2h_r, two_x_r;
  logic signed [63:0] tx_r, tbx_r, td2_r, p1_r, p2_r, e_r, y1_r, y2_r;
  logic [SEC_W-1:0]   tk_r;
  logic signed [31:0] fs_r;
  logic               sat_r;

  logic               acc;
  logic [CNT_W-1:0]   sec_sum, nsec, k_ext, k_inc;
  logic [SEC_W-1:0]   k_nx;
  logic               more, is_hp, out_free, sec_ok, sel_ok;
  logic signed [32:0] diff;
  logic signed [63:0] x0, off_sh, d1_rd, d2_rd, q_prod;
  logic               fits;

  logic               coef_we;
  logic [CA_W-1:0]    coef_waddr, coef_raddr;
  logic signed [31:0] coef_rdata;
  logic               dly_we;
  logic [SEC_W-1:0]   dly_raddr;
  logic [DLY_W-1:0]   dly_wdata, dly_rdata;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign sec_sum = CNT_W'(cfg.highpass_sections) + CNT_W'(cfg.lowpass_sections);
  assign nsec    = (sec_sum > CNT_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS) : sec_sum;
  assign k_ext   = CNT_W'(k_r);
  assign k_inc   = k_ext + CNT_W'(1);
  assign k_nx    = k_inc[SEC_W-1:0];
  assign more    = (k_inc < nsec);
  assign is_hp   = (k_ext < CNT_W'(cfg.highpass_sections));

  assign diff   = 33'(in_sample) - 33'(cfg.offset);
  assign x0     = 64'(diff) <<< SIG_FRAC;
  assign off_sh = 64'(cfg.offset) <<< SIG_FRAC;

  assign d1_rd = rd_vld_r ? $signed(dly_rdata[127:64]) : 64'sd0;
  assign d2_rd = rd_vld_r ? $signed(dly_rdata[63:0]) : 64'sd0;

  // coefficient store
  assign sec_ok = (CNT_W'(in_section) < CNT_W'(MAX_SECTIONS));
  assign sel_ok = (in_coef_sel == SEL_A1) || (in_coef_sel == SEL_A2) ||
                  (in_coef_sel == SEL_GAIN);
  assign coef_we    = acc && (in_op == OP_COEF) && sec_ok && sel_ok;
  assign coef_waddr = {in_section[SEC_W-1:0], in_coef_sel};

  always_comb begin
    coef_raddr = '0;
    if (state_r == S_PRE2) begin
      coef_raddr = {SEC_W'(0), SEL_GAIN};
    end else if (state_r == S_RUN) begin
      unique case (ph_r)
        PH_GAIN: coef_raddr = {k_r, SEL_A1};
        PH_A1:   coef_raddr = {k_r, SEL_A2};
        default: coef_raddr = {k_nx, SEL_GAIN};
      endcase
    end
  end

  bcf_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // delay store: {first, second}, written back one section behind
  assign dly_we    = tv_r && (((state_r == S_RUN) && (ph_r == PH_A1)) || (state_r == S_DR1));
  assign dly_wdata = {sat_add(e_r, td2_r), sat_sub(tx_r, p2_r)};
  assign dly_raddr = ((state_r == S_RUN) && (ph_r == PH_A1) && more) ? k_nx : '0;

  bcf_ram #(.WIDTH(DLY_W), .DEPTH(MAX_SECTIONS)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (tk_r),
    .wdata (dly_wdata),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  bcf_qmul u_qmul (
    .clk  (clk),
    .v    (v_r),
    .c    (coef_rdata),
    .prod (q_prod)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && (in_op == OP_FILTER)) begin
          state_nxt = (nsec == '0) ? S_DR0 : S_PRE1;
        end
      end
      S_PRE1: state_nxt = S_PRE2;
      S_PRE2: state_nxt = S_RUN;
      S_RUN: begin
        if ((ph_r == PH_A2) && !more) begin
          state_nxt = S_DR0;
        end
      end
      S_DR0: state_nxt = S_DR1;
      S_DR1: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_GAIN;
      k_r         <= '0;
      tv_r        <= 1'b0;
      dly_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= dly_vld_r[dly_raddr];
      if (acc) begin
        tv_r <= 1'b0;
        k_r  <= '0;
      end
      if (acc && (in_op == OP_CLEAR)) begin
        dly_vld_r <= '0;
      end else if (dly_we) begin
        dly_vld_r[tk_r] <= 1'b1;
      end
      if (state_r == S_PRE2) begin
        ph_r <= PH_GAIN;
        k_r  <= '0;
      end else if (state_r == S_RUN) begin
        if (ph_r == PH_A2) begin
          ph_r <= PH_GAIN;
          tv_r <= 1'b1;
          if (more) begin
            k_r <= k_nx;
          end
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign fits = (&y2_r[63:CLIP_HI]) || ~(|y2_r[63:CLIP_HI]);

  always_ff @(posedge clk) begin
    if (acc && (in_op == OP_FILTER)) begin
      x_r  <= x0;
      xn_r <= x0;
    end
    unique case (state_r)
      S_PRE2: begin
        v_r   <= sat_add(xn_r, d1_rd);
        d2h_r <= d2_rd;
      end
      S_RUN: begin
        unique case (ph_r)
          PH_GAIN: begin
            two_x_r <= sat_add(x_r, x_r);
            p2_r    <= q_prod;
            e_r     <= sat_sub(tbx_r, p1_r);
          end
          PH_A1: begin
            xn_r <= q_prod;
          end
          default: begin
            p1_r  <= q_prod;
            tx_r  <= x_r;
            tbx_r <= is_hp ? sat_sub(64'sd0, two_x_r) : two_x_r;
            td2_r <= d2h_r;
            tk_r  <= k_r;
            x_r   <= xn_r;
            if (more) begin
              v_r   <= sat_add(xn_r, d1_rd);
              d2h_r <= d2_rd;
            end
          end
        endcase
      end
      S_DR0: begin
        p2_r <= q_prod;
        e_r  <= sat_sub(tbx_r, p1_r);
        y1_r <= sat_add(x_r, off_sh);
      end
      S_DR1: begin
        y2_r <= sat_add(y1_r, ROUND_HALF);
      end
      S_FIN: begin
        if (out_free) begin
          fs_r  <= fits ? y2_r[CLIP_HI:SIG_FRAC] : (y2_r[63] ? S32_MIN : S32_MAX);
          sat_r <= !fits;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = fs_r;
  assign out_saturated       = sat_r;

endmodule
`default_nettype wire

[rtl/biquad_cascade_filter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_cascade_filter_top: cascade of high-pass then low-pass biquad sections
// A sample item is taken only while the core is idle; the next item is taken once
// the result item is registered, later while the previous result item waits on
// out_ready. Each section runs three coefficient products through the shared
// multiplier. Coefficient and clear items leave the core idle. Synchronous rst_n
// clears config and marks all delays zero at once; coefficients stay undefined
// until written.
// ----------------------------------------------------------------------------
module biquad_cascade_filter_top import bcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bcf_in_if.sink            in_ch,
  bcf_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HP:     cfg_r.highpass_sections <= pwdata[2:0];
        REG_LP:     cfg_r.lowpass_sections  <= pwdata[2:0];
        REG_OFFSET: cfg_r.offset            <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HP:     prdata = 32'(cfg_r.highpass_sections);
      REG_LP:     prdata = 32'(cfg_r.lowpass_sections);
      REG_OFFSET: prdata = cfg_r.offset;
      default:    prdata = '0;
    endcase
  end

  bcf_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_op               (in_ch.op),
    .in_sample           (in_ch.sample),
    .in_section          (in_ch.section),
    .in_coef_sel         (in_ch.coef_sel),
    .in_coef_value       (in_ch.coef_value),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_filtered_sample (out_ch.filtered_sample),
    .out_saturated       (out_ch.saturated)
  );

endmodule
`default_nettype wire

[rtl/bcf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_port_checks
// Port-level checks of the biquad cascade, bound to the top level.
// ----------------------------------------------------------------------------
module bcf_port_checks import bcf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_op,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_filtered_sample,
  input logic               out_saturated
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_sample) &&
                                $stable(out_saturated))
    else $error("result item changed while stalled");

  a_ctl_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op != OP_FILTER) |=> in_ready)
    else $error("non-filter item did not return to ready");

  a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == OP_FILTER) |=> !in_ready)
    else $error("ready while a sample is in progress");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == OP_FILTER) |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too early");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_filtered_sample == S32_MAX) || (out_filtered_sample == S32_MIN))
    else $error("saturated flag without full-scale value");

endmodule

bind biquad_cascade_filter_top bcf_port_checks u_bcf_port_checks (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_op               (in_ch.op),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_filtered_sample (out_ch.filtered_sample),
  .out_saturated       (out_ch.saturated)
);
`default_nettype wire

[dv/bcf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcf_checker
// Watches the item channels and the register port of the biquad cascade,
// predicts every filtered sample from its own copy of coefficients, delays and
// registers, and compares each result item field by field in order.
// ----------------------------------------------------------------------------
module bcf_checker import bcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bcf_in_if                 in_mon,
  bcf_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               clipped;
  } filt_res_t;

  cfg_t               cfg;
  logic signed [31:0] pole1 [MAX_SECTIONS];
  logic signed [31:0] pole2 [MAX_SECTIONS];
  logic signed [31:0] gain  [MAX_SECTIONS];
  logic signed [63:0] dly1  [MAX_SECTIONS];
  logic signed [63:0] dly2  [MAX_SECTIONS];
  filt_res_t          expected_outputs [$];
  int                 fail_count = 0;
  int                 queued     = 0;

  assign mismatches = fail_count;
  assign pending    = queued;

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic logic signed [63:0] add_clip(input logic signed [63:0] a, b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sub_clip(input logic signed [63:0] a, b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  // product rounded half-up at 2^-30, clipped to 64 bits
  function automatic logic signed [63:0] scale_q30(input logic signed [63:0] v,
                                                    input logic signed [31:0] c);
    logic signed [95:0] prod;
    logic signed [65:0] q;
    prod = $signed({{32{v[63]}}, v}) * $signed({{64{c[31]}}, c});
    prod = prod + 96'sd536870912;
    q = prod[95:30];
    if (q[65:63] != 3'b000 && q[65:63] != 3'b111) begin
      return q[65] ? S64_MIN : S64_MAX;
    end
    return q[63:0];
  endfunction

  function automatic filt_res_t filter_sample(input logic signed [31:0] smp);
    logic signed [63:0] x, v, p1, p2, twice, bx, off_q, y;
    int unsigned        active;
    filt_res_t          r;
    off_q = cfg.offset;
    off_q = off_q <<< SIG_FRAC;
    x = smp;
    x = (x <<< SIG_FRAC) - off_q;
    active = cfg.highpass_sections + cfg.lowpass_sections;
    if (active > MAX_SECTIONS) begin
      active = MAX_SECTIONS;
    end
    for (int k = 0; k < active; k++) begin
      v = add_clip(x, dly1[k]);
      p1 = scale_q30(v, pole1[k]);
      p2 = scale_q30(v, pole2[k]);
      twice = add_clip(x, x);
      bx = (k < cfg.highpass_sections) ? sub_clip(64'sd0, twice) : twice;
      dly1[k] = add_clip(sub_clip(bx, p1), dly2[k]);
      dly2[k] = sub_clip(x, p2);
      x = scale_q30(v, gain[k]);
    end
    y = add_clip(add_clip(x, off_q), ROUND_HALF);
    y = y >>> SIG_FRAC;
    r.clipped = 1'b1;
    if (y > S32_MAX) begin
      r.value = S32_MAX;
    end else if (y < S32_MIN) begin
      r.value = S32_MIN;
    end else begin
      r.value = y[31:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    filt_res_t want;
    if (!rst_n) begin
      cfg = '0;
      for (int k = 0; k < MAX_SECTIONS; k++) begin
        dly1[k] = '0;
        dly2[k] = '0;
      end
      expected_outputs.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_outputs.size() == 0) begin
          flag_error($sformatf("result %0d with no item waiting", out_mon.filtered_sample));
        end else begin
          want = expected_outputs.pop_front();
          if (out_mon.filtered_sample !== want.value) begin
            flag_error($sformatf("filtered_sample %0d, predicted %0d",
                                 out_mon.filtered_sample, want.value));
          end
          if (out_mon.saturated !== want.clipped) begin
            flag_error($sformatf("saturated %b, predicted %b",
                                 out_mon.saturated, want.clipped));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_HP:     cfg.highpass_sections = pwdata[2:0];
          REG_LP:     cfg.lowpass_sections = pwdata[2:0];
          REG_OFFSET: cfg.offset = pwdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_FILTER: expected_outputs.push_back(filter_sample(in_mon.sample));
          OP_COEF: begin
            if (in_mon.section < MAX_SECTIONS) begin
              case (in_mon.coef_sel)
                SEL_A1:   pole1[in_mon.section] = in_mon.coef_value;
                SEL_A2:   pole2[in_mon.section] = in_mon.coef_value;
                SEL_GAIN: gain[in_mon.section] = in_mon.coef_value;
                default: ;
              endcase
            end
          end
          OP_CLEAR: begin
            for (int k = 0; k < MAX_SECTIONS; k++) begin
              dly1[k] = '0;
              dly2[k] = '0;
            end
          end
          default: ;
        endcase
      end
    end
    queued = expected_outputs.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the biquad cascade with directed corner items and randomized phases
// of samples, coefficient writes and delay clears under random flow control,
// reconfiguring between phases, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import bcf_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 3 * MAX_SECTIONS + 24;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] SEL_NONE  = 2'd3;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                mismatches;
  int                pending;
  int                idle_pct    = 26;
  int                quiet_count = 0;

  bcf_in_if  in_ch ();
  bcf_out_if out_ch ();

  always #(HALF_PERIOD) clk = ~clk;

  biquad_cascade_filter_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bcf_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] op, input logic signed [31:0] smp,
                           input logic [3:0] sec, input logic [1:0] sel,
                           input logic signed [31:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.op         = op;
    in_ch.sample     = smp;
    in_ch.section    = sec;
    in_ch.coef_sel   = sel;
    in_ch.coef_value = val;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic push_filter(input logic signed [31:0] smp);
    push_item(OP_FILTER, smp, 4'($urandom), 2'($urandom), $urandom);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input int hp, input int lp, input logic signed [31:0] off);
    in_ch.valid = 1'b0;
    wait_drained();
    write_reg(REG_HP, hp);
    write_reg(REG_LP, lp);
    write_reg(REG_OFFSET, off);
  endtask

  // stable poles unless wild: a2 in [0, 0.9), |a1| at most 0.9 * (1 + a2)
  task automatic load_coefs(input bit wild);
    logic signed [31:0] a1, a2, g;
    int unsigned        lim;
    for (int k = 0; k < MAX_SECTIONS; k++) begin
      if (wild) begin
        a1 = $urandom;
        a2 = $urandom;
        g  = $urandom;
      end else begin
        a2  = $urandom_range(0, 966367641);
        lim = ((32'd1 << 30) + a2) / 10 * 9;
        a1  = $urandom_range(0, 2 * lim) - lim;
        g   = $urandom_range(Q30_ONE / 8, Q30_ONE);
      end
      push_item(OP_COEF, $urandom, 4'(k), SEL_A1, a1);
      push_item(OP_COEF, $urandom, 4'(k), SEL_A2, a2);
      push_item(OP_COEF, $urandom, 4'(k), SEL_GAIN, g);
    end
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
      1, 2, 3: return $signed($urandom_range(0, 8191)) - 4096;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return S32_MAX;
      2:       return S32_MIN;
      3:       return $signed($urandom_range(0, 65535)) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random_item();
    int                 r;
    logic signed [31:0] val;
    r   = $urandom_range(0, 99);
    val = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 858993459) - 429496729;
    if (r < 82) begin
      push_item(OP_FILTER, pick_sample(), 4'($urandom), 2'($urandom), $urandom);
    end else if (r < 91) begin
      push_item(OP_COEF, $urandom, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), val);
    end else if (r < 96) begin
      push_item(OP_CLEAR, $urandom, 4'($urandom), 2'($urandom), $urandom);
    end else begin
      push_item(OP_UNUSED, $urandom, 4'($urandom), 2'($urandom), $urandom);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_FILTER;
    in_ch.sample     = '0;
    in_ch.section    = '0;
    in_ch.coef_sel   = SEL_A1;
    in_ch.coef_value = '0;
    out_ch.ready     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // pass-through with no sections, ignored ops and writes
    configure(0, 0, 0);
    push_filter(S32_MIN);
    push_filter(S32_MAX);
    push_filter(0);
    push_filter(-1);
    push_item(OP_UNUSED, 5, 4'd0, SEL_A1, 0);
    push_item(OP_COEF, 0, 4'd15, SEL_GAIN, S32_MAX);
    push_item(OP_COEF, 0, 4'd12, SEL_A1, S32_MIN);
    push_item(OP_COEF, 0, 4'd0, SEL_NONE, S32_MAX);

    load_coefs(1'b0);
    configure(6, 6, S32_MIN);
    push_filter(S32_MAX);
    push_filter(S32_MIN);
    push_filter(0);
    push_item(OP_CLEAR, 0, 4'd0, SEL_A1, 0);
    push_filter(32'sd1 <<< 20);
    repeat (3) push_filter(0);

    // counts beyond the section store
    configure(7, 7, S32_MAX);
    push_filter(S32_MIN);
    push_filter(S32_MAX);
    load_coefs(1'b1);
    push_filter(S32_MAX);
    push_filter(S32_MIN);
    push_filter(12345);

    for (int ph = 0; ph < 9; ph++) begin
      load_coefs(ph % 4 == 2);
      case (ph)
        0:       configure(1, 0, pick_offset());
        1:       configure(0, 1, pick_offset());
        2:       configure(6, 6, S32_MIN);
        3:       configure(2, 2, 0);
        4:       configure(7, 0, S32_MAX);
        5:       configure(0, 7, pick_offset());
        default: configure($urandom_range(0, 7), $urandom_range(0, 7), pick_offset());
      endcase
      idle_pct = (ph == 3) ? 0 : 26;
      repeat (55) push_random_item();
    end

    in_ch.valid = 1'b0;
    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bcf_pkg.sv
rtl/bcf_if.sv
rtl/bcf_ram.sv
rtl/bcf_qmul.sv
rtl/bcf_core.sv
rtl/biquad_cascade_filter_top.sv
rtl/bcf_checker.sv
dv/bcf_checker.sv
dv/tb_top.sv
